// ===== rtl/ifs_pkg.sv =====
// ----------------------------------------------------------------------------
// ifs_pkg
// Shared types and constants of the chaos-game step engine.
// ----------------------------------------------------------------------------
package ifs_pkg;

  localparam int unsigned MaxMaps  = 8;
  localparam int unsigned FracBits = 16;
  localparam int unsigned IdxW     = $clog2(MaxMaps);
  localparam int unsigned PtW      = 20;
  localparam int unsigned PxW      = 16;
  localparam int unsigned ProbW    = 17;
  localparam int unsigned SumW     = ProbW + IdxW;

  localparam logic signed [PtW-1:0] PtMax = {1'b0, {(PtW-1){1'b1}}};
  localparam logic signed [PtW-1:0] PtMin = {1'b1, {(PtW-1){1'b0}}};

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_STEP    = 2'd1,
    KIND_RESTART = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    REG_MODE  = 3'd0,
    REG_COUNT = 3'd1,
    REG_VX    = 3'd2,
    REG_VY    = 3'd3,
    REG_VW    = 3'd4,
    REG_VH    = 3'd5
  } reg_e;

  // classified command from front to back
  typedef struct packed {
    logic            restart;
    logic            hit;
    logic [IdxW-1:0] pick;
  } cmd_t;

  function automatic logic signed [PtW-1:0] sat_pt(input logic signed [47:0] v);
    if (v > 48'(PtMax)) return PtMax;
    if (v < 48'(PtMin)) return PtMin;
    return v[PtW-1:0];
  endfunction

  function automatic logic signed [PxW-1:0] sat_px(input logic signed [40:0] v);
    if (v > 41'sd32767) return 16'sh7fff;
    if (v < -41'sd32768) return 16'sh8000;
    return v[PxW-1:0];
  endfunction

endpackage

// ===== rtl/ifs_front.sv =====
// ----------------------------------------------------------------------------
// ifs_front
// Accepts items, loads map tables, scans cumulative weights of step items
// one map per cycle and queues classified commands for the back end.
// ----------------------------------------------------------------------------
module ifs_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [1:0]                    kind_i,
  input  logic [2:0]                    map_index_i,
  input  logic signed [19:0]            coef_a_i,
  input  logic signed [19:0]            coef_b_i,
  input  logic signed [19:0]            coef_c_i,
  input  logic signed [19:0]            coef_d_i,
  input  logic signed [19:0]            coef_e_i,
  input  logic signed [19:0]            coef_f_i,
  input  logic [16:0]                   probability_i,
  input  logic [15:0]                   random_sample_i,
  input  logic [3:0]                    map_count_i,
  output logic                          cmd_valid_o,
  output ifs_pkg::cmd_t                 cmd_o,
  input  logic                          cmd_pop_i,
  input  logic [ifs_pkg::IdxW-1:0]      coef_addr_i,
  output logic signed [6*ifs_pkg::PtW-1:0] coef_rdata_o
);
  import ifs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  localparam int unsigned QDepth = 2;

  logic [6*PtW-1:0] coef_mem [MaxMaps];
  logic [ProbW-1:0] prob_q [MaxMaps];

  state_e            state_q, state_d;
  logic [15:0]       sample_q;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [IdxW:0]     idx_q, idx_d;
  logic [IdxW:0]     limit_q;
  logic [IdxW:0]     limit_d;

  cmd_t              fifo_q [QDepth];
  logic              wr_q, rd_q;
  logic [1:0]        cnt_q;
  logic              q_push;
  cmd_t              q_in;
  logic              q_full;
  logic              accept;
  logic [SumW-1:0]   sum_next;

  assign q_full = (cnt_q == 2'(QDepth));
  // a load waits until queued steps have read their coefficients
  assign full_o = (state_q != ST_IDLE) || q_full || (kind_i == KIND_LOAD && cnt_q != 0);
  assign accept = push_i && !full_o;
  assign limit_d = (map_count_i > 4'(MaxMaps)) ? (IdxW+1)'(MaxMaps) : map_count_i[IdxW:0];
  assign sum_next = sum_q + SumW'(prob_q[idx_q[IdxW-1:0]]);

  always_ff @(posedge clk_i) begin
    if (accept && kind_i == KIND_LOAD) begin
      coef_mem[map_index_i] <= {coef_f_i, coef_e_i, coef_d_i, coef_c_i, coef_b_i, coef_a_i};
      prob_q[map_index_i]   <= probability_i;
    end
    coef_rdata_o <= coef_mem[coef_addr_i];
  end

  always_comb begin
    state_d = state_q;
    sum_d   = sum_q;
    idx_d   = idx_q;
    q_push  = 1'b0;
    q_in    = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept && kind_i == KIND_STEP) begin
          state_d = ST_SCAN;
          sum_d   = '0;
          idx_d   = '0;
        end else if (accept && kind_i == KIND_RESTART) begin
          q_push       = 1'b1;
          q_in.restart = 1'b1;
        end
      end
      ST_SCAN: begin
        if (idx_q >= limit_q) begin
          q_push  = 1'b1;
          state_d = ST_IDLE;
        end else if (32'(sample_q) <= 32'(sum_next)) begin
          q_push  = 1'b1;
          q_in.hit  = 1'b1;
          q_in.pick = idx_q[IdxW-1:0];
          state_d = ST_IDLE;
        end else begin
          sum_d = sum_next;
          idx_d = idx_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (q_push) begin
        wr_q <= ~wr_q;
      end
      if (cmd_pop_i && cnt_q != 0) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(q_push) - 2'(cmd_pop_i && cnt_q != 0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && kind_i == KIND_STEP) begin
      sample_q <= random_sample_i;
      limit_q  <= limit_d;
    end
    sum_q <= sum_d;
    idx_q <= idx_d;
    if (q_push) begin
      fifo_q[wr_q] <= q_in;
    end
  end

  assign cmd_valid_o = (cnt_q != 0);
  assign cmd_o       = fifo_q[rd_q];

endmodule

// ===== rtl/ifs_back.sv =====
// ----------------------------------------------------------------------------
// ifs_back
// Applies the chosen affine map to the held point, tracks bounds or scales
// to pixels, and holds results in a two-entry output queue.
// ----------------------------------------------------------------------------
module ifs_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  ifs_pkg::cmd_t                 cmd_i,
  output logic                          cmd_pop_o,
  output logic [ifs_pkg::IdxW-1:0]      coef_addr_o,
  input  logic signed [6*ifs_pkg::PtW-1:0] coef_rdata_i,
  input  logic                          measure_mode_i,
  input  logic signed [15:0]            view_x_i,
  input  logic signed [15:0]            view_y_i,
  input  logic [12:0]                   view_w_i,
  input  logic [12:0]                   view_h_i,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic signed [19:0]            point_x_o,
  output logic signed [19:0]            point_y_o,
  output logic                          matched_o,
  output logic [2:0]                    chosen_map_o,
  output logic                          plot_valid_o,
  output logic signed [15:0]            pixel_x_o,
  output logic signed [15:0]            pixel_y_o,
  output logic signed [19:0]            min_x_o,
  output logic signed [19:0]            max_x_o,
  output logic signed [19:0]            min_y_o,
  output logic signed [19:0]            max_y_o
);
  import ifs_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RD   = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_PIX  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  typedef struct packed {
    logic signed [PtW-1:0] px, py;
    logic                  hit;
    logic [2:0]            pick;
    logic                  plot;
    logic signed [PxW-1:0] pxx, pxy;
    logic signed [PtW-1:0] lx, hx, ly, hy;
  } res_t;

  state_e state_q, state_d;
  logic signed [PtW-1:0] cx_q, cy_q, lx_q, hx_q, ly_q, hy_q;
  logic signed [40:0] ax_q, bx_q, cxp_q, dy_q;
  logic signed [PtW-1:0] e_q, f_q;
  logic [IdxW-1:0] pick_q;
  logic signed [PtW-1:0] ca, cb, cc, cd;
  logic signed [47:0] nx, ny;
  logic signed [PtW-1:0] nxs, nys;
  logic signed [34:0] mx_q, my_q;
  logic signed [20:0] oy;
  logic plot_q;

  res_t oq [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;
  logic opush;
  res_t ores;

  assign ca = coef_rdata_i[0*PtW +: PtW];
  assign cb = coef_rdata_i[1*PtW +: PtW];
  assign cc = coef_rdata_i[2*PtW +: PtW];
  assign cd = coef_rdata_i[3*PtW +: PtW];

  assign coef_addr_o = cmd_i.pick;
  assign cmd_pop_o   = (state_q == ST_IDLE) && cmd_valid_i && cnt_q != 2'd2;

  assign nx  = 48'(ax_q) + 48'(bx_q) + (48'(e_q) <<< FracBits);
  assign ny  = 48'(cxp_q) + 48'(dy_q) + (48'(f_q) <<< FracBits);
  assign nxs = sat_pt(nx >>> FracBits);
  assign nys = sat_pt(ny >>> FracBits);
  assign oy  = (21'sd1 <<< FracBits) - 21'(cy_q);

  always_comb begin
    state_d = state_q;
    opush   = 1'b0;
    ores    = '0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_pop_o) begin
          if (cmd_i.restart) begin
            state_d = ST_IDLE;
          end else if (cmd_i.hit) begin
            state_d = ST_RD;
          end else begin
            opush = 1'b1;
            ores.px = cx_q; ores.py = cy_q;
            ores.lx = lx_q; ores.hx = hx_q; ores.ly = ly_q; ores.hy = hy_q;
          end
        end
      end
      ST_RD:  state_d = ST_MUL;
      ST_MUL: state_d = measure_mode_i ? ST_OUT : ST_PIX;
      ST_PIX: state_d = ST_OUT;
      ST_OUT: begin
        state_d   = ST_IDLE;
        opush     = 1'b1;
        ores.px   = cx_q; ores.py = cy_q;
        ores.hit  = 1'b1;
        ores.pick = 3'(pick_q);
        ores.plot = plot_q;
        ores.pxx  = plot_q ? sat_px(41'(mx_q >>> FracBits) + 41'(view_x_i)) : '0;
        ores.pxy  = plot_q ? sat_px(41'(my_q >>> FracBits) + 41'(view_y_i)) : '0;
        ores.lx = lx_q; ores.hx = hx_q; ores.ly = ly_q; ores.hy = hy_q;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cx_q <= '0; cy_q <= '0;
      lx_q <= PtMax; ly_q <= PtMax; hx_q <= PtMin; hy_q <= PtMin;
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= '0;
      plot_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_pop_o && cmd_i.restart) begin
        cx_q <= '0; cy_q <= '0;
        lx_q <= PtMax; ly_q <= PtMax; hx_q <= PtMin; hy_q <= PtMin;
      end
      if (state_q == ST_MUL) begin
        cx_q   <= nxs;
        cy_q   <= nys;
        plot_q <= !measure_mode_i;
        if (measure_mode_i) begin
          if (nxs < lx_q) lx_q <= nxs;
          if (nxs > hx_q) hx_q <= nxs;
          if (nys < ly_q) ly_q <= nys;
          if (nys > hy_q) hy_q <= nys;
        end
      end
      if (opush) wr_q <= ~wr_q;
      if (pop_i && cnt_q != 0) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(opush) - 2'(pop_i && cnt_q != 0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) pick_q <= cmd_i.pick;
    if (state_q == ST_RD) begin
      ax_q  <= ca * cx_q;
      bx_q  <= cb * cy_q;
      cxp_q <= cc * cx_q;
      dy_q  <= cd * cy_q;
      e_q   <= coef_rdata_i[4*PtW +: PtW];
      f_q   <= coef_rdata_i[5*PtW +: PtW];
    end
    if (state_q == ST_PIX) begin
      mx_q <= cx_q * $signed({1'b0, view_w_i});
      my_q <= oy * $signed({1'b0, view_h_i});
    end
    if (opush) oq[wr_q] <= ores;
  end

  assign empty_o      = (cnt_q == 0);
  assign point_x_o    = oq[rd_q].px;
  assign point_y_o    = oq[rd_q].py;
  assign matched_o    = oq[rd_q].hit;
  assign chosen_map_o = oq[rd_q].pick;
  assign plot_valid_o = oq[rd_q].plot;
  assign pixel_x_o    = oq[rd_q].pxx;
  assign pixel_y_o    = oq[rd_q].pxy;
  assign min_x_o      = oq[rd_q].lx;
  assign max_x_o      = oq[rd_q].hx;
  assign min_y_o      = oq[rd_q].ly;
  assign max_y_o      = oq[rd_q].hy;

endmodule

// ===== rtl/ifs_chaos_game_step_top.sv =====
// ----------------------------------------------------------------------------
// ifs_chaos_game_step_top
// Chaos-game step engine for a 2D iterated function system.
// ----------------------------------------------------------------------------
// Input channel: push/full. A beat is a load, step or restart item.
// Loads and restarts are handled in the front end; a load is held off
// while the command queue still holds entries. A step scans the
// cumulative weights one map per cycle, then the front is free for the
// next item while the back end works.
// Back end: command pop, coefficient read, affine multiply, pixel multiply
// (skipped in measure mode) and result write; when nothing matched, the
// result is written at the command pop.
// Result channel: empty/pop, backed by a two-entry result queue. When
// the receiver stalls, the queue fills, the back end halts, the two-entry
// command queue fills and full rises.
// Reset empties both queues, zeros the point, sets the bounds to the
// empty box and the registers to their defaults; the map table is
// undefined until loaded. Config writes (cfg_we_i) take effect at once.
// ----------------------------------------------------------------------------
module ifs_chaos_game_step_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         kind_i,
  input  logic [2:0]         map_index_i,
  input  logic signed [19:0] coef_a_i,
  input  logic signed [19:0] coef_b_i,
  input  logic signed [19:0] coef_c_i,
  input  logic signed [19:0] coef_d_i,
  input  logic signed [19:0] coef_e_i,
  input  logic signed [19:0] coef_f_i,
  input  logic [16:0]        probability_i,
  input  logic [15:0]        random_sample_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [19:0] point_x_o,
  output logic signed [19:0] point_y_o,
  output logic               matched_o,
  output logic [2:0]         chosen_map_o,
  output logic               plot_valid_o,
  output logic signed [15:0] pixel_x_o,
  output logic signed [15:0] pixel_y_o,
  output logic signed [19:0] min_x_o,
  output logic signed [19:0] max_x_o,
  output logic signed [19:0] min_y_o,
  output logic signed [19:0] max_y_o
);
  import ifs_pkg::*;

  logic               mode_q;
  logic [3:0]         count_q;
  logic signed [15:0] vx_q, vy_q;
  logic [12:0]        vw_q, vh_q;
  logic               cmd_valid, cmd_pop;
  cmd_t               cmd;
  logic [IdxW-1:0]    coef_addr;
  logic signed [6*PtW-1:0] coef_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0; count_q <= 4'd1;
      vx_q <= '0; vy_q <= '0; vw_q <= '0; vh_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MODE:  mode_q  <= cfg_data_i[0];
        REG_COUNT: count_q <= cfg_data_i[3:0];
        REG_VX:    vx_q    <= cfg_data_i;
        REG_VY:    vy_q    <= cfg_data_i;
        REG_VW:    vw_q    <= cfg_data_i[12:0];
        REG_VH:    vh_q    <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  ifs_front u_front (
    .clk_i, .rst_ni,
    .push_i(push), .full_o(full),
    .kind_i, .map_index_i,
    .coef_a_i, .coef_b_i, .coef_c_i, .coef_d_i, .coef_e_i, .coef_f_i,
    .probability_i, .random_sample_i,
    .map_count_i(count_q),
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop),
    .coef_addr_i(coef_addr), .coef_rdata_o(coef_rdata)
  );

  ifs_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .coef_addr_o(coef_addr), .coef_rdata_i(coef_rdata),
    .measure_mode_i(mode_q),
    .view_x_i(vx_q), .view_y_i(vy_q), .view_w_i(vw_q), .view_h_i(vh_q),
    .empty_o(empty), .pop_i(pop),
    .point_x_o, .point_y_o, .matched_o, .chosen_map_o, .plot_valid_o,
    .pixel_x_o, .pixel_y_o, .min_x_o, .max_x_o, .min_y_o, .max_y_o
  );

endmodule

// ===== rtl/ifs_checker.sv =====
// ----------------------------------------------------------------------------
// ifs_checker
// Port-level checks of the chaos-game step engine.
// ----------------------------------------------------------------------------
module ifs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input logic               matched_o,
  input logic [2:0]         chosen_map_o,
  input logic               plot_valid_o,
  input logic signed [15:0] pixel_x_o,
  input logic signed [15:0] pixel_y_o
);

  a_plot_needs_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && plot_valid_o |-> matched_o) else $error("plot without match");

  a_nomatch_map_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !matched_o |-> chosen_map_o == 3'd0) else $error("map on miss");

  a_noplot_pix_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !plot_valid_o |-> pixel_x_o == 16'sd0 && pixel_y_o == 16'sd0)
    else $error("pixel without plot");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty) else $error("result lost");

endmodule

bind ifs_chaos_game_step_top ifs_checker u_checker (
  .clk_i, .rst_ni, .empty, .pop, .matched_o, .chosen_map_o, .plot_valid_o,
  .pixel_x_o, .pixel_y_o
);

// ===== tb/ifs_chaos_game_step_top_tb.sv =====
// ----------------------------------------------------------------------------
// ifs_chaos_game_step_top_tb
// Self-checking bench for the chaos-game step engine: a directed table of
// loads, steps and restarts, then random phases under varying view, mode and
// map count settings, with bursty pushes and a stalling receiver. Every step
// result is compared field by field against an in-bench affine predictor.
// ----------------------------------------------------------------------------
module ifs_chaos_game_step_top_tb;
  import ifs_pkg::*;

  localparam logic [1:0] KindUnused = 2'd3;
  localparam int         IdleLimit  = 5000;
  localparam int         NumPhases  = 11;
  localparam int         PhaseItems = 150;

  typedef struct {
    logic [1:0]         kind;
    logic [2:0]         slot;
    logic signed [19:0] a, b, c, d, e, f;
    logic [16:0]        prob;
    logic [15:0]        sample;
  } item_t;

  typedef struct packed {
    logic signed [19:0] px, py;
    logic               hit;
    logic [2:0]         pick;
    logic               plot;
    logic signed [15:0] pix_x, pix_y;
    logic signed [19:0] lo_x, hi_x, lo_y, hi_y;
  } step_res_t;

  typedef struct {
    item_t              it;
    bit                 typed;
    logic signed [19:0] tx, ty;
    logic               thit;
  } row_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_index_i;
  logic [15:0] cfg_data_i;
  logic push, full, empty, pop;
  logic [1:0] kind_i;
  logic [2:0] map_index_i;
  logic signed [19:0] coef_a_i, coef_b_i, coef_c_i, coef_d_i, coef_e_i, coef_f_i;
  logic [16:0] probability_i;
  logic [15:0] random_sample_i;
  logic signed [19:0] point_x_o, point_y_o;
  logic matched_o, plot_valid_o;
  logic [2:0] chosen_map_o;
  logic signed [15:0] pixel_x_o, pixel_y_o;
  logic signed [19:0] min_x_o, max_x_o, min_y_o, max_y_o;

  ifs_chaos_game_step_top dut (.*);

  // predictor state
  bit     mode_measure;
  int     maps_used;
  longint org_x, org_y, scale_w, scale_h;
  longint map_coef[8][6];
  longint map_weight[8];
  longint pt_x, pt_y, box_lo_x, box_hi_x, box_lo_y, box_hi_y;

  step_res_t step_q[$];
  row_t      rows[$];
  int        errors, n_steps, n_hits, n_plots, n_beats;
  bit        hold_req;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic step_res_t step_predict(logic [15:0] smp);
    step_res_t r;
    longint    sum, nx, ny, qx, qy;
    int        lim, pick;
    bit        hit;
    sum = 0; hit = 0; pick = 0; qx = 0; qy = 0;
    lim = maps_used > 8 ? 8 : maps_used;
    for (int i = 0; i < lim; i++) begin
      sum += map_weight[i];
      if (!hit && longint'(smp) <= sum) begin
        hit = 1;
        pick = i;
      end
    end
    r.plot = 0;
    if (hit) begin
      nx = map_coef[pick][0] * pt_x + map_coef[pick][1] * pt_y + (map_coef[pick][4] <<< 16);
      ny = map_coef[pick][2] * pt_x + map_coef[pick][3] * pt_y + (map_coef[pick][5] <<< 16);
      pt_x = sat(nx >>> 16, -524288, 524287);
      pt_y = sat(ny >>> 16, -524288, 524287);
      if (mode_measure) begin
        if (pt_x < box_lo_x) box_lo_x = pt_x;
        if (pt_x > box_hi_x) box_hi_x = pt_x;
        if (pt_y < box_lo_y) box_lo_y = pt_y;
        if (pt_y > box_hi_y) box_hi_y = pt_y;
      end else begin
        r.plot = 1;
        qx = sat(((pt_x * scale_w) >>> 16) + org_x, -32768, 32767);
        qy = sat((((65536 - pt_y) * scale_h) >>> 16) + org_y, -32768, 32767);
      end
    end
    r.px = pt_x[19:0]; r.py = pt_y[19:0];
    r.hit = hit; r.pick = hit ? pick[2:0] : 3'd0;
    r.pix_x = qx[15:0]; r.pix_y = qy[15:0];
    r.lo_x = box_lo_x[19:0]; r.hi_x = box_hi_x[19:0];
    r.lo_y = box_lo_y[19:0]; r.hi_y = box_hi_y[19:0];
    return r;
  endfunction

  task automatic clear_point();
    pt_x = 0; pt_y = 0;
    box_lo_x = 524287; box_lo_y = 524287;
    box_hi_x = -524288; box_hi_y = -524288;
  endtask

  task automatic apply_item(row_t rw);
    step_res_t r;
    case (rw.it.kind)
      KIND_LOAD: begin
        map_coef[rw.it.slot][0] = rw.it.a; map_coef[rw.it.slot][1] = rw.it.b;
        map_coef[rw.it.slot][2] = rw.it.c; map_coef[rw.it.slot][3] = rw.it.d;
        map_coef[rw.it.slot][4] = rw.it.e; map_coef[rw.it.slot][5] = rw.it.f;
        map_weight[rw.it.slot] = rw.it.prob;
      end
      KIND_RESTART: clear_point();
      KIND_STEP: begin
        r = step_predict(rw.it.sample);
        if (rw.typed) begin
          r.px = rw.tx; r.py = rw.ty; r.hit = rw.thit;
        end
        step_q.push_back(r);
        n_steps++;
        n_hits += r.hit;
        n_plots += r.plot;
      end
      default: ;
    endcase
  endtask

  // push stays high across back-to-back items; only idle_for lowers it
  task automatic push_item(row_t rw);
    push <= 1'b1;
    kind_i <= rw.it.kind; map_index_i <= rw.it.slot;
    coef_a_i <= rw.it.a; coef_b_i <= rw.it.b; coef_c_i <= rw.it.c;
    coef_d_i <= rw.it.d; coef_e_i <= rw.it.e; coef_f_i <= rw.it.f;
    probability_i <= rw.it.prob; random_sample_i <= rw.it.sample;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    apply_item(rw);
  endtask

  task automatic idle_for(int n);
    push <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    idle_for(1);
    while (step_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [15:0] v);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MODE:  mode_measure = v[0];
      REG_COUNT: maps_used = v[3:0];
      REG_VX:    org_x = longint'(signed'(v));
      REG_VY:    org_y = longint'(signed'(v));
      REG_VW:    scale_w = v[12:0];
      REG_VH:    scale_h = v[12:0];
      default: ;
    endcase
  endtask

  task automatic add_row(logic [1:0] k, logic [2:0] s, int a, int b, int c, int d,
                         int e, int f, int p, int smp, bit typed = 0,
                         int tx = 0, int ty = 0, bit thit = 0);
    row_t rw;
    rw.it = '{k, s, a[19:0], b[19:0], c[19:0], d[19:0], e[19:0], f[19:0],
              p[16:0], smp[15:0]};
    rw.typed = typed; rw.tx = tx[19:0]; rw.ty = ty[19:0]; rw.thit = thit;
    rows.push_back(rw);
  endtask

  function automatic logic signed [19:0] rand_coef(int span);
    if ($urandom_range(0, 7) == 0) return 20'($urandom);
    return 20'($urandom_range(0, 2 * span) - span);
  endfunction

  function automatic row_t rand_row();
    row_t rw;
    int   sel;
    sel = $urandom_range(0, 99);
    rw.typed = 0;
    rw.it.kind = sel < 15 ? KIND_LOAD : sel < 90 ? KIND_STEP :
                 sel < 97 ? KIND_RESTART : KindUnused;
    rw.it.slot = 3'($urandom_range(0, 7));
    rw.it.a = rand_coef(45000); rw.it.b = rand_coef(45000);
    rw.it.c = rand_coef(45000); rw.it.d = rand_coef(45000);
    rw.it.e = rand_coef(131072); rw.it.f = rand_coef(131072);
    case ($urandom_range(0, 9))
      0:       rw.it.prob = 0;
      1:       rw.it.prob = 65536;
      default: rw.it.prob = 17'($urandom_range(0, 20000));
    endcase
    case ($urandom_range(0, 9))
      0:       rw.it.sample = 0;
      1:       rw.it.sample = 16'hffff;
      default: rw.it.sample = 16'($urandom);
    endcase
    return rw;
  endfunction

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    step_res_t x;
    if (rst_ni && pop && !empty) begin
      n_beats++;
      if (step_q.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        errors++;
      end else begin
        x = step_q.pop_front();
        check_field("point_x", x.px, point_x_o);
        check_field("point_y", x.py, point_y_o);
        check_field("matched", x.hit, matched_o);
        check_field("chosen_map", x.pick, chosen_map_o);
        check_field("plot_valid", x.plot, plot_valid_o);
        check_field("pixel_x", x.pix_x, pixel_x_o);
        check_field("pixel_y", x.pix_y, pixel_y_o);
        check_field("min_x", x.lo_x, min_x_o);
        check_field("max_x", x.hi_x, max_x_o);
        check_field("min_y", x.lo_y, min_y_o);
        check_field("max_y", x.hi_y, max_y_o);
      end
    end
  end

  // receiver: picks a new random stall pattern per window, plus one long hold-off
  initial begin
    int pat;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      pat = $urandom_range(0, 3);
      for (int i = 0; i < 64; i++) begin
        @(posedge clk_i);
        if (hold_req) begin
          hold_req = 0;
          pop <= 1'b0;
          repeat (400) @(posedge clk_i);
        end
        case (pat)
          0:       pop <= 1'b1;
          1:       pop <= $urandom_range(0, 1);
          2:       pop <= ($urandom_range(0, 4) == 0);
          default: pop <= (i % 8) < 5;
        endcase
      end
    end
  end

  // watchdog
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
      if (quiet >= IdleLimit) begin
        $display("%0t: no beat for %0d cycles", $time, IdleLimit);
        $display("** ifs_chaos_game_step_top: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int burst;
    errors = 0; n_steps = 0; n_hits = 0; n_plots = 0; n_beats = 0; hold_req = 0;
    mode_measure = 0; maps_used = 1;
    org_x = 0; org_y = 0; scale_w = 0; scale_h = 0;
    clear_point();
    rst_ni = 1'b0; cfg_we_i = 1'b0; cfg_index_i = REG_MODE; cfg_data_i = '0;
    push = 1'b0; kind_i = KIND_LOAD; map_index_i = '0;
    coef_a_i = '0; coef_b_i = '0; coef_c_i = '0; coef_d_i = '0;
    coef_e_i = '0; coef_f_i = '0; probability_i = '0; random_sample_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: fill every slot, then extremes, no-match and restart
    add_row(KIND_LOAD, 0, 0, 0, 0, 0, 65536, -65536, 65536, 0);
    add_row(KIND_LOAD, 1, 524287, 524287, 524287, 524287, 524287, 524287, 0, 0);
    add_row(KIND_LOAD, 2, -524288, -524288, -524288, -524288, -524288, -524288, 0, 0);
    for (int s = 3; s < 8; s++)
      add_row(KIND_LOAD, s, 32768, -16384, 16384, 32768, s * 4096, -s * 4096, 8192, 0);
    add_row(KIND_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 65536, -65536, 1);
    add_row(KIND_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 65535, 1, 65536, -65536, 1);
    add_row(KindUnused, 7, -1, -1, -1, -1, -1, -1, 131071, 65535);
    add_row(KIND_RESTART, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(KIND_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 12345, 1, 65536, -65536, 1);
    add_row(KIND_LOAD, 0, 524287, 0, 0, -524288, 524287, -524288, 0, 0);
    add_row(KIND_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 65536, -65536, 0);
    add_row(KIND_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(KIND_STEP, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(KIND_RESTART, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(KIND_LOAD, 0, 30000, 10000, -10000, 30000, 20000, 10000, 40000, 0);
    foreach (rows[i]) push_item(rows[i]);

    for (int p = 0; p < NumPhases; p++) begin
      drain();
      write_reg(REG_MODE, 16'(p % 3 == 1));
      write_reg(REG_COUNT, 16'(p == 1 ? 0 : p == 2 ? 15 : p == 3 ? 1 : $urandom_range(2, 8)));
      write_reg(REG_VX, p == 2 ? 16'h8000 : p == 3 ? 16'h7fff : 16'($urandom));
      write_reg(REG_VY, p == 3 ? 16'h8000 : p == 2 ? 16'h7fff : 16'($urandom));
      write_reg(REG_VW, 16'(p == 2 ? 0 : p == 3 ? 8191 : $urandom_range(0, 8191)));
      write_reg(REG_VH, 16'(p == 3 ? 0 : p == 2 ? 8191 : $urandom_range(0, 8191)));
      if (p == 4) hold_req = 1;
      for (int n = 0; n < PhaseItems; ) begin
        burst = $urandom_range(1, 20);
        for (int k = 0; k < burst && n < PhaseItems; k++, n++) push_item(rand_row());
        if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 15));
      end
    end

    drain();
    $display("Covered %0d steps (%0d matched, %0d plotted), %0d result beats,",
             n_steps, n_hits, n_plots, n_beats);
    $display("over %0d phases of mode, map count and view settings.", NumPhases);
    if (errors == 0) begin
      $display("** ifs_chaos_game_step_top: PASSED **");
    end else begin
      $display("** ifs_chaos_game_step_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== ifs_chaos_game_step_top.f =====
rtl/ifs_pkg.sv
rtl/ifs_front.sv
rtl/ifs_back.sv
rtl/ifs_chaos_game_step_top.sv
rtl/ifs_checker.sv
tb/ifs_chaos_game_step_top_tb.sv
